FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL of the tone to hue/saturation unit.
// Expects a clock named clk and an active high synchronous reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define XYHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define XYHS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/xyhs_pkg.sv
// Types, constants and step functions for the tone to hue/saturation unit.
// No dependencies; used by every module of the block.
package xyhs_pkg;

  localparam logic [29:0] COS30_Q30       = 30'd929887697;
  localparam logic [31:0] RESET_DEAD_ZONE = 32'd107374;
  localparam logic [16:0] HUE_MAX         = 17'd131071;
  localparam logic [3:0]  CNT_HALF        = 4'd6;
  localparam logic [3:0]  CNT_QUARTER     = 4'd3;
  localparam int          TURNS           = 3;

  localparam int ISQ_STAGES = 8;   // two root bits per stage
  localparam int NUM_W      = 54;
  localparam int DEN_W      = 36;
  localparam int QUO_W      = 18;
  localparam int DIV_STAGES = 1 + QUO_W / 2;

  typedef struct packed {
    logic [17:0] rem;
    logic [15:0] root;
  } isq_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } dv_t;

  // Vector after folding, carried alongside the root computation.
  typedef struct packed {
    logic [31:0] ux;
    logic [31:0] uy;
    logic [3:0]  cnt;
    logic        zero;
  } fold_t;

  typedef struct packed {
    logic [15:0] sat;
    logic        zero;
  } div_aux_t;

  function automatic isq_t isq_step(isq_t s, logic [1:0] d);
    logic [19:0] r;
    logic [19:0] t;
    isq_t        o;
    r = {s.rem, d};
    t = {2'b00, s.root, 2'b01};
    if (r >= t) begin
      o.rem  = 18'(r - t);
      o.root = {s.root[14:0], 1'b1};
    end else begin
      o.rem  = r[17:0];
      o.root = {s.root[14:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t div_step(dv_t s, logic b, logic [DEN_W-1:0] d);
    logic [DEN_W:0] t;
    dv_t            o;
    t = {s.rem, b};
    if (t >= {1'b0, d}) begin
      o.rem = DEN_W'(t - {1'b0, d});
      o.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = t[DEN_W-1:0];
      o.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: hdl/xyhs_isqrt.sv
// Pipelined integer square root of a 32-bit value, two result bits per stage.
// Depends on xyhs_pkg; carries a side payload of AUX_W bits along.
module xyhs_isqrt #(
  parameter int AUX_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      in_rad,
  input  logic [AUX_W-1:0] in_aux,
  output logic             out_valid,
  output logic [15:0]      out_root,
  output logic [AUX_W-1:0] out_aux
);
  import xyhs_pkg::*;

  logic [ISQ_STAGES-1:0] vld;
  logic [31:0]           rad [ISQ_STAGES];
  isq_t                  st  [ISQ_STAGES];
  logic [AUX_W-1:0]      aux [ISQ_STAGES];

  for (genvar g = 0; g < ISQ_STAGES; g++) begin : g_stage
    logic             pv;
    logic [31:0]      prad;
    isq_t             pst;
    logic [AUX_W-1:0] paux;

    if (g == 0) begin : g_first
      assign pv   = in_valid;
      assign prad = in_rad;
      assign pst  = '0;
      assign paux = in_aux;
    end else begin : g_next
      assign pv   = vld[g-1];
      assign prad = rad[g-1];
      assign pst  = st[g-1];
      assign paux = aux[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[g] <= {prad[27:0], 4'b0000};
        st[g]  <= isq_step(isq_step(pst, prad[31:30]), prad[29:28]);
        aux[g] <= paux;
      end
    end
  end

  assign out_valid = vld[ISQ_STAGES-1];
  assign out_root  = st[ISQ_STAGES-1].root;
  assign out_aux   = aux[ISQ_STAGES-1];

endmodule

FILE: hdl/xyhs_div.sv
// Pipelined restoring divider: 54-bit numerator over 36-bit denominator,
// 18 quotient bits, two per stage, with an overflow flag. Depends on xyhs_pkg.
module xyhs_div #(
  parameter int AUX_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [xyhs_pkg::NUM_W-1:0] in_num,
  input  logic [xyhs_pkg::DEN_W-1:0] in_den,
  input  logic [AUX_W-1:0]           in_aux,
  output logic                       out_valid,
  output logic [xyhs_pkg::QUO_W-1:0] out_quo,
  output logic                       out_ovf,
  output logic [AUX_W-1:0]           out_aux
);
  import xyhs_pkg::*;

  logic [DIV_STAGES-1:0] vld;
  dv_t                   st  [DIV_STAGES];
  logic [QUO_W-1:0]      lo  [DIV_STAGES];
  logic [DEN_W-1:0]      den [DIV_STAGES];
  logic                  ovf [DIV_STAGES];
  logic [AUX_W-1:0]      aux [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic pv;
    if (g == 0) begin : g_first
      assign pv = in_valid;
      // Upper numerator bits seed the remainder; a quotient that would not
      // fit in QUO_W bits shows up here.
      always_ff @(posedge clk) begin
        if (en) begin
          st[g].rem <= in_num[NUM_W-1:QUO_W];
          st[g].quo <= '0;
          lo[g]     <= in_num[QUO_W-1:0];
          den[g]    <= in_den;
          ovf[g]    <= (in_num[NUM_W-1:QUO_W] >= in_den);
          aux[g]    <= in_aux;
        end
      end
    end else begin : g_next
      assign pv = vld[g-1];
      always_ff @(posedge clk) begin
        if (en) begin
          st[g]  <= div_step(div_step(st[g-1], lo[g-1][QUO_W-1], den[g-1]),
                             lo[g-1][QUO_W-2], den[g-1]);
          lo[g]  <= {lo[g-1][QUO_W-3:0], 2'b00};
          den[g] <= den[g-1];
          ovf[g] <= ovf[g-1];
          aux[g] <= aux[g-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= pv;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_quo   = st[DIV_STAGES-1].quo;
  assign out_ovf   = ovf[DIV_STAGES-1];
  assign out_aux   = aux[DIV_STAGES-1];

endmodule

FILE: hdl/xy_tone_to_hue_saturation_unit.sv
// Top level of the tone vector to hue/saturation converter.
// Depends on xyhs_pkg, xyhs_isqrt, xyhs_div and assert_macros.svh.
//
// Usage:
//   s_tdata carries one tone vector (x_tone, y_tone), both signed.
//   m_tdata returns hue_turns (unsigned Q1.16) and saturation (length).
//   cfg_wr_en/cfg_wr_data write the squared-length dead zone (Q2.30);
//   vectors whose squared length falls below it give zero hue and
//   saturation. Write it only while no request is in flight.
//   A request goes through 28 register stages to m_tdata, the first loaded
//   at the edge that accepts it. Throughput is one request per cycle unless
//   the receiver stalls: every stage is a register with a valid bit, the
//   root takes 8 stages, the three 30 degree rotations take two stages each
//   (multiply, then add) and the hue division 10 stages.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads the dead zone with 107374.
module xy_tone_to_hue_saturation_unit #(
  parameter int TONE_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // [15:0] x_tone, [31:16] y_tone
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,     // [16:0] hue_turns, [32:17] saturation
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import xyhs_pkg::*;

  localparam int SQ_D   = 2 * TONE_FRAC_BITS - 30;
  localparam int SQ_SHL = (SQ_D < 0) ? -SQ_D : 0;
  localparam int SQ_SHR = (SQ_D > 0) ? SQ_D : 0;

  logic        en;
  logic [31:0] dead_zone;

  // Output register
  logic        m_valid;
  logic [16:0] m_hue;
  logic [15:0] m_sat;

  assign en       = !m_valid || m_tready;
  assign s_tready = en;
  assign m_tvalid = m_valid;
  assign m_tdata  = {7'b0, m_sat, m_hue};

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= RESET_DEAD_ZONE;
    end else if (cfg_wr_en) begin
      dead_zone <= cfg_wr_data;
    end
  end

  // Stage 1: squares
  logic               v1;
  logic signed [15:0] x1, y1;
  logic [30:0]        xx1, yy1;
  logic signed [31:0] xx_full, yy_full;

  assign xx_full = $signed(s_tdata[15:0]) * $signed(s_tdata[15:0]);
  assign yy_full = $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= s_tdata[15:0];
      y1  <= s_tdata[31:16];
      xx1 <= xx_full[30:0];
      yy1 <= yy_full[30:0];
    end
  end

  // Stage 2: dead zone and folding to the first quadrant
  logic               v2;
  logic [31:0]        sq2;
  fold_t              fold2;
  logic [31:0]        sq_c;
  logic [63:0]        scaled;
  logic signed [16:0] fx, fy, gx, gy;
  logic [3:0]         cnt_a, cnt_b;
  fold_t              fold_c;

  always_comb begin
    sq_c   = {1'b0, xx1} + {1'b0, yy1};
    scaled = ({32'b0, sq_c} << SQ_SHL) >> SQ_SHR;
    fx     = 17'(x1);
    fy     = 17'(y1);
    cnt_a  = '0;
    if (y1 < 0) begin
      fx    = -17'(x1);
      fy    = -17'(y1);
      cnt_a = CNT_HALF;
    end
    gx    = fx;
    gy    = fy;
    cnt_b = cnt_a;
    if (fx < 0) begin
      gx    = fy;
      gy    = -fx;
      cnt_b = cnt_a + CNT_QUARTER;
    end
    fold_c.ux   = {gx[15:0], 16'b0};
    fold_c.uy   = {gy[15:0], 16'b0};
    fold_c.cnt  = cnt_b;
    fold_c.zero = (scaled < {32'b0, dead_zone}) || (sq_c == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq2   <= sq_c;
      fold2 <= fold_c;
    end
  end

  // Length
  logic        v3;
  logic [15:0] root3;
  fold_t       fold3;

  xyhs_isqrt #(
    .AUX_W($bits(fold_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .in_rad   (sq2),
    .in_aux   (fold2),
    .out_valid(v3),
    .out_root (root3),
    .out_aux  (fold3)
  );

  // Rotations: stage A multiplies and decides, stage B adds and shifts
  logic [TURNS-1:0] va, vb;
  logic [31:0]      ax  [TURNS];
  logic [31:0]      ay  [TURNS];
  logic [61:0]      pxa [TURNS];
  logic [61:0]      pya [TURNS];
  logic             rot [TURNS];
  logic [3:0]       ca  [TURNS];
  div_aux_t         da  [TURNS];
  logic [31:0]      bx  [TURNS];
  logic [31:0]      by  [TURNS];
  logic [3:0]       cb  [TURNS];
  div_aux_t         db  [TURNS];

  for (genvar g = 0; g < TURNS; g++) begin : g_turn
    logic        pv;
    logic [31:0] px, py;
    logic [3:0]  pc;
    div_aux_t    pd;
    logic [34:0] five_y, three_x;
    logic [63:0] sum_x, a_y, b_x;
    logic [31:0] nx, ny;

    if (g == 0) begin : g_first
      assign pv      = v3;
      assign px      = fold3.ux;
      assign py      = fold3.uy;
      assign pc      = fold3.cnt;
      assign pd.sat  = root3;
      assign pd.zero = fold3.zero;
    end else begin : g_next
      assign pv = vb[g-1];
      assign px = bx[g-1];
      assign py = by[g-1];
      assign pc = cb[g-1];
      assign pd = db[g-1];
    end

    assign five_y  = {py, 2'b00} + {3'b000, py};
    assign three_x = {2'b00, px, 1'b0} + {3'b000, px};

    always_ff @(posedge clk) begin
      if (rst) begin
        va[g] <= 1'b0;
        vb[g] <= 1'b0;
      end else if (en) begin
        va[g] <= pv;
        vb[g] <= va[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ax[g]  <= px;
        ay[g]  <= py;
        pxa[g] <= {30'b0, px} * {32'b0, COS30_Q30};
        pya[g] <= {30'b0, py} * {32'b0, COS30_Q30};
        rot[g] <= (five_y > three_x);
        ca[g]  <= pc;
        da[g]  <= pd;
      end
    end

    always_comb begin
      sum_x = {2'b00, pxa[g]} + {3'b000, ay[g], 29'b0};
      a_y   = {2'b00, pya[g]};
      b_x   = {3'b000, ax[g], 29'b0};
      nx    = sum_x[61:30];
      ny    = (a_y >= b_x) ? 32'((a_y - b_x) >> 30) : 32'd0;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bx[g] <= rot[g] ? nx : ax[g];
        by[g] <= rot[g] ? ny : ay[g];
        cb[g] <= rot[g] ? ca[g] + 4'd1 : ca[g];
        db[g] <= da[g];
      end
    end
  end

  // Division operands: (cnt*x + 2y) * 2^16 + 6x over 12x, or cnt * 2^16 over 12
  logic             vp;
  logic [NUM_W-1:0] nump;
  logic [DEN_W-1:0] denp;
  div_aux_t         dp;
  logic [35:0]      prod_c;
  logic [36:0]      lin_c;
  logic [DEN_W-1:0] den_c;
  logic [NUM_W-1:0] num_c;

  always_comb begin
    prod_c = {4'b0, bx[TURNS-1]} * {32'b0, cb[TURNS-1]};
    lin_c  = {1'b0, prod_c} + {4'b0, by[TURNS-1], 1'b0};
    den_c  = {1'b0, bx[TURNS-1], 3'b000} + {2'b00, bx[TURNS-1], 2'b00};
    num_c  = {1'b0, lin_c, 16'b0} + {19'b0, den_c[DEN_W-1:1]};
    if (bx[TURNS-1] == '0) begin
      den_c = DEN_W'(12);
      num_c = {34'b0, cb[TURNS-1], 16'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= vb[TURNS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nump <= num_c;
      denp <= den_c;
      dp   <= db[TURNS-1];
    end
  end

  logic             vq;
  logic [QUO_W-1:0] quo;
  logic             ovf;
  div_aux_t         dq;

  xyhs_div #(
    .AUX_W($bits(div_aux_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vp),
    .in_num   (nump),
    .in_den   (denp),
    .in_aux   (dp),
    .out_valid(vq),
    .out_quo  (quo),
    .out_ovf  (ovf),
    .out_aux  (dq)
  );

  // Output: clamp hue, zero both inside the dead zone
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dq.zero) begin
        m_hue <= '0;
        m_sat <= '0;
      end else begin
        m_hue <= (ovf || quo > {1'b0, HUE_MAX}) ? HUE_MAX : quo[16:0];
        m_sat <= dq.sat;
      end
    end
  end

`include "assert_macros.svh"

  `XYHS_ASSERT(a_stall_holds_input, (m_valid && !m_tready) |-> !s_tready, "input taken during output stall")
  `XYHS_ASSERT(a_zero_sat_zero_hue, (m_valid && m_sat == '0) |-> (m_hue == '0), "hue without saturation")
  `XYHS_ASSERT_ALWAYS(a_reset_dead_zone, rst |=> (dead_zone == RESET_DEAD_ZONE), "dead zone not reset")
  `XYHS_ASSERT_ALWAYS(a_reset_out_idle, rst |=> !m_valid, "output valid after reset")

endmodule
